// ===== design/jfhp_pkg.sv =====
package jfhp_pkg;

  localparam logic [7:0] BYTE_FF    = 8'hFF;
  localparam logic [7:0] BYTE_00    = 8'h00;
  localparam logic [7:0] MARK_SOI   = 8'hD8;
  localparam logic [7:0] MARK_EOI   = 8'hD9;
  localparam logic [7:0] MARK_TEM   = 8'h01;
  localparam logic [7:0] MARK_RST0  = 8'hD0;
  localparam logic [7:0] MARK_RST7  = 8'hD7;
  localparam logic [7:0] MARK_SOS   = 8'hDA;
  localparam logic [7:0] MARK_SOF0  = 8'hC0;
  localparam logic [7:0] MARK_SOF15 = 8'hCF;
  localparam logic [7:0] MARK_DHT   = 8'hC4;
  localparam logic [7:0] MARK_JPG   = 8'hC8;
  localparam logic [7:0] MARK_DAC   = 8'hCC;

  localparam logic [1:0] STATUS_NOT_JPEG = 2'd0;
  localparam logic [1:0] STATUS_NO_DIMS  = 2'd1;
  localparam logic [1:0] STATUS_DIMS     = 2'd2;

  localparam logic [7:0] COMP_DEFAULT = 8'd3;
  localparam logic [2:0] SEEN_MIN     = 3'd4;
  localparam logic [2:0] OFFSET_MAX   = 3'd7;
  localparam logic [15:0] LEN_MIN     = 16'd2;
  localparam logic [15:0] SOF_LEN_MIN = 16'd8;

  localparam int OUT_TDATA_W = 48;

  typedef enum logic [11:0] {
    MODE_HDR0    = 12'b0000_0000_0001,
    MODE_HDR1    = 12'b0000_0000_0010,
    MODE_SEEK    = 12'b0000_0000_0100,
    MODE_FILL    = 12'b0000_0000_1000,
    MODE_LEN_HI  = 12'b0000_0001_0000,
    MODE_LEN_LO  = 12'b0000_0010_0000,
    MODE_BODY    = 12'b0000_0100_0000,
    MODE_ENTROPY = 12'b0000_1000_0000,
    MODE_ENT_FF  = 12'b0001_0000_0000,
    MODE_STOP    = 12'b0010_0000_0000,
    MODE_FOUND   = 12'b0100_0000_0000,
    MODE_BAD     = 12'b1000_0000_0000
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  sof;
  } marker_t;

  function automatic logic is_rst(input logic [7:0] b);
    return (b >= MARK_RST0) && (b <= MARK_RST7);
  endfunction

  // decode the byte that follows one or more ff bytes
  function automatic marker_t take_marker(input logic [7:0] b, input logic sof_in);
    marker_t m;
    m.sof = sof_in;
    if (b == BYTE_FF) begin
      m.mode = MODE_FILL;
    end else if (b == MARK_SOI || b == MARK_EOI) begin
      m.mode = MODE_STOP;
    end else if (b == MARK_TEM || is_rst(b)) begin
      m.mode = MODE_SEEK;
    end else if (b == MARK_SOS) begin
      m.mode = MODE_ENTROPY;
    end else begin
      m.sof  = (b >= MARK_SOF0) && (b <= MARK_SOF15) &&
               (b != MARK_DHT) && (b != MARK_JPG) && (b != MARK_DAC);
      m.mode = MODE_LEN_HI;
    end
    return m;
  endfunction

endpackage

// ===== design/jpeg_frame_header_parser_core.sv =====
// Takes a JPEG file one byte per beat on the in_ channel (in_tlast on the final byte) and walks
// its marker segments; on the final byte it sends one beat with status (not JPEG, JPEG without
// dimensions, dimensions found) and the frame width, height and component count from the first
// complete SOF segment. A byte is taken every cycle except while the pipe is held; out_tvalid rises
// once the last byte has passed the registered input stage and the output register. A result waiting
// on out_tready holds the pipe only when the next last byte reaches the parse stage.
module jpeg_frame_header_parser_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // data_byte[7:0]
  input  logic                                in_tlast,   // last_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status[1:0], width[17:2], height[33:18], components[41:34], zero[47:42]
  output logic [jfhp_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  // input stage
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       out_free;

  // parse state
  jfhp_pkg::mode_t mode_r, mode_nxt, mode_s;
  logic [2:0]  seen_r, seen_nxt, seen_s;
  logic [15:0] rem_r, rem_nxt, rem_s;
  logic [7:0]  len_hi_r, len_hi_nxt, len_hi_s;
  logic        sof_r, sof_nxt, sof_s;
  logic [2:0]  ofs_r, ofs_nxt, ofs_s;
  logic [15:0] hgt_r, hgt_nxt, hgt_s;
  logic [15:0] wid_r, wid_nxt, wid_s;
  logic [7:0]  comp_r, comp_nxt, comp_s;

  logic [15:0] seg_len;
  logic [15:0] rem_dec;
  jfhp_pkg::marker_t mk;

  logic [1:0]  res_status;
  logic [15:0] res_wid;
  logic [15:0] res_hgt;
  logic [7:0]  res_comp;

  logic                             out_vld_r;
  logic [jfhp_pkg::OUT_TDATA_W-1:0] out_data_r;

  assign out_free  = !out_vld_r || out_tready;
  assign s1_adv    = s1_vld_r && (!s1_last_r || out_free);
  assign in_tready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  assign seg_len = {len_hi_r, s1_byte_r};
  assign rem_dec = rem_r - 16'd1;

  always_comb begin
    mode_s   = mode_r;
    seen_s   = seen_r;
    rem_s    = rem_r;
    len_hi_s = len_hi_r;
    sof_s    = sof_r;
    ofs_s    = ofs_r;
    hgt_s    = hgt_r;
    wid_s    = wid_r;
    comp_s   = comp_r;
    mk       = jfhp_pkg::take_marker(s1_byte_r, sof_r);

    if (seen_r < jfhp_pkg::SEEN_MIN) begin
      seen_s = seen_r + 3'd1;
    end

    case (mode_r)
      jfhp_pkg::MODE_HDR0: begin
        mode_s = (s1_byte_r == jfhp_pkg::BYTE_FF) ? jfhp_pkg::MODE_HDR1 : jfhp_pkg::MODE_BAD;
      end
      jfhp_pkg::MODE_HDR1: begin
        mode_s = (s1_byte_r == jfhp_pkg::MARK_SOI) ? jfhp_pkg::MODE_SEEK : jfhp_pkg::MODE_BAD;
      end
      jfhp_pkg::MODE_SEEK: begin
        if (s1_byte_r == jfhp_pkg::BYTE_FF) begin
          mode_s = jfhp_pkg::MODE_FILL;
        end
      end
      jfhp_pkg::MODE_FILL: begin
        mode_s = mk.mode;
        sof_s  = mk.sof;
      end
      jfhp_pkg::MODE_LEN_HI: begin
        len_hi_s = s1_byte_r;
        mode_s   = jfhp_pkg::MODE_LEN_LO;
      end
      jfhp_pkg::MODE_LEN_LO: begin
        if (seg_len < jfhp_pkg::LEN_MIN || (sof_r && seg_len < jfhp_pkg::SOF_LEN_MIN)) begin
          mode_s = jfhp_pkg::MODE_STOP;
        end else begin
          rem_s  = seg_len - jfhp_pkg::LEN_MIN;
          ofs_s  = 3'd0;
          mode_s = (seg_len == jfhp_pkg::LEN_MIN) ? jfhp_pkg::MODE_SEEK : jfhp_pkg::MODE_BODY;
        end
      end
      jfhp_pkg::MODE_BODY: begin
        if (sof_r) begin
          case (ofs_r)
            3'd1:    hgt_s  = {s1_byte_r, 8'h00};
            3'd2:    hgt_s  = {hgt_r[15:8], s1_byte_r};
            3'd3:    wid_s  = {s1_byte_r, 8'h00};
            3'd4:    wid_s  = {wid_r[15:8], s1_byte_r};
            3'd5:    comp_s = s1_byte_r;
            default: ;
          endcase
        end
        if (ofs_r < jfhp_pkg::OFFSET_MAX) begin
          ofs_s = ofs_r + 3'd1;
        end
        rem_s = rem_dec;
        if (rem_dec == 16'd0) begin
          mode_s = sof_r ? jfhp_pkg::MODE_FOUND : jfhp_pkg::MODE_SEEK;
        end
      end
      jfhp_pkg::MODE_ENTROPY: begin
        if (s1_byte_r == jfhp_pkg::BYTE_FF) begin
          mode_s = jfhp_pkg::MODE_ENT_FF;
        end
      end
      jfhp_pkg::MODE_ENT_FF: begin
        // stuffed zero or restart keeps us in scan data
        if (s1_byte_r == jfhp_pkg::BYTE_00 || jfhp_pkg::is_rst(s1_byte_r)) begin
          mode_s = jfhp_pkg::MODE_ENTROPY;
        end else begin
          mode_s = mk.mode;
          sof_s  = mk.sof;
        end
      end
      default: ;
    endcase

    if (seen_s < jfhp_pkg::SEEN_MIN || mode_s == jfhp_pkg::MODE_BAD ||
        mode_s == jfhp_pkg::MODE_HDR0 || mode_s == jfhp_pkg::MODE_HDR1) begin
      res_status = jfhp_pkg::STATUS_NOT_JPEG;
      res_wid    = 16'd0;
      res_hgt    = 16'd0;
      res_comp   = jfhp_pkg::COMP_DEFAULT;
    end else if (mode_s == jfhp_pkg::MODE_FOUND) begin
      res_status = jfhp_pkg::STATUS_DIMS;
      res_wid    = wid_s;
      res_hgt    = hgt_s;
      res_comp   = comp_s;
    end else begin
      res_status = jfhp_pkg::STATUS_NO_DIMS;
      res_wid    = 16'd0;
      res_hgt    = 16'd0;
      res_comp   = jfhp_pkg::COMP_DEFAULT;
    end

    // end of file puts everything back for the next file
    if (s1_last_r) begin
      mode_nxt   = jfhp_pkg::MODE_HDR0;
      seen_nxt   = 3'd0;
      rem_nxt    = 16'd0;
      len_hi_nxt = 8'd0;
      sof_nxt    = 1'b0;
      ofs_nxt    = 3'd0;
      hgt_nxt    = 16'd0;
      wid_nxt    = 16'd0;
      comp_nxt   = jfhp_pkg::COMP_DEFAULT;
    end else begin
      mode_nxt   = mode_s;
      seen_nxt   = seen_s;
      rem_nxt    = rem_s;
      len_hi_nxt = len_hi_s;
      sof_nxt    = sof_s;
      ofs_nxt    = ofs_s;
      hgt_nxt    = hgt_s;
      wid_nxt    = wid_s;
      comp_nxt   = comp_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= jfhp_pkg::MODE_HDR0;
      seen_r   <= 3'd0;
      rem_r    <= 16'd0;
      len_hi_r <= 8'd0;
      sof_r    <= 1'b0;
      ofs_r    <= 3'd0;
      hgt_r    <= 16'd0;
      wid_r    <= 16'd0;
      comp_r   <= jfhp_pkg::COMP_DEFAULT;
    end else if (s1_adv) begin
      mode_r   <= mode_nxt;
      seen_r   <= seen_nxt;
      rem_r    <= rem_nxt;
      len_hi_r <= len_hi_nxt;
      sof_r    <= sof_nxt;
      ofs_r    <= ofs_nxt;
      hgt_r    <= hgt_nxt;
      wid_r    <= wid_nxt;
      comp_r   <= comp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_adv && s1_last_r;
    end
    if (out_free && s1_adv && s1_last_r) begin
      out_data_r <= {6'd0, res_comp, res_hgt, res_wid, res_status};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/jfhp_checker.sv =====
module jfhp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [jfhp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == jfhp_pkg::STATUS_NOT_JPEG ||
                    out_tdata[1:0] == jfhp_pkg::STATUS_NO_DIMS ||
                    out_tdata[1:0] == jfhp_pkg::STATUS_DIMS))
    else $error("bad status code");

  // without dimensions the fields carry their defaults
  a_defaults: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != jfhp_pkg::STATUS_DIMS |->
      out_tdata[17:2] == 16'd0 && out_tdata[33:18] == 16'd0 &&
      out_tdata[41:34] == jfhp_pkg::COMP_DEFAULT && out_tdata[47:42] == 6'd0)
    else $error("default fields wrong");

  // a fresh result beat comes from a last byte that has passed the input stage and the output register
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a last byte");

endmodule

bind jpeg_frame_header_parser_core jfhp_checker u_jfhp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/jpeg_frame_header_parser_core_tb.sv =====
module jpeg_frame_header_parser_core_tb;
  import jfhp_pkg::*;

  localparam logic [7:0] MARK_APP0 = 8'hE0;
  localparam logic [7:0] MARK_DQT  = 8'hDB;
  localparam logic [7:0] MARK_COM  = 8'hFE;

  localparam int unsigned RANDOM_BEATS     = 450;
  localparam int unsigned HOLD_AFTER_FILES = 8;
  localparam int unsigned HOLD_CYCLES      = 250;
  localparam int unsigned DRAIN_LIMIT      = 2000;
  localparam int unsigned MAX_REPORTS      = 10;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  comps;
  } frame_info_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        lst;
    logic        typed;
    frame_info_t want;
  } directed_row_t;

  localparam frame_info_t NOT_JPEG_INFO = {STATUS_NOT_JPEG, 16'd0, 16'd0, COMP_DEFAULT};
  localparam frame_info_t NO_DIMS_INFO  = {STATUS_NO_DIMS, 16'd0, 16'd0, COMP_DEFAULT};
  localparam frame_info_t FULL_DIMS     = {STATUS_DIMS, 16'hFFFF, 16'hFFFF, 8'hFF};
  localparam frame_info_t NO_INFO       = '0;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  jpeg_frame_header_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // marker walk, one byte at a time
  mode_t       walk_mode;
  logic [2:0]  walk_seen;
  logic [15:0] walk_left;
  logic [7:0]  walk_len_hi;
  logic        walk_sof;
  logic [2:0]  walk_off;
  logic [15:0] walk_height;
  logic [15:0] walk_width;
  logic [7:0]  walk_comps;

  frame_info_t   pending_frames[$];
  directed_row_t directed_rows[$];
  logic [7:0]    file_bytes[$];

  int unsigned files_sent;
  int unsigned beats_sent;
  int unsigned frames_checked;
  int unsigned dims_seen;
  int unsigned mismatches;
  logic        sink_holding;
  logic        hold_done;

  task automatic walk_reset();
    walk_mode   = MODE_HDR0;
    walk_seen   = '0;
    walk_left   = '0;
    walk_len_hi = '0;
    walk_sof    = 1'b0;
    walk_off    = '0;
    walk_height = '0;
    walk_width  = '0;
    walk_comps  = COMP_DEFAULT;
  endtask

  function automatic logic restart_code(input logic [7:0] b);
    return (b >= MARK_RST0) && (b <= MARK_RST7);
  endfunction

  function automatic logic sof_code(input logic [7:0] b);
    return (b >= MARK_SOF0) && (b <= MARK_SOF15) &&
           (b != MARK_DHT) && (b != MARK_JPG) && (b != MARK_DAC);
  endfunction

  task automatic enter_marker(input logic [7:0] b);
    if (b == BYTE_FF) begin
      walk_mode = MODE_FILL;
    end else if (b == MARK_SOI || b == MARK_EOI) begin
      walk_mode = MODE_STOP;
    end else if (b == MARK_TEM || restart_code(b)) begin
      walk_mode = MODE_SEEK;
    end else if (b == MARK_SOS) begin
      walk_mode = MODE_ENTROPY;
    end else begin
      walk_sof  = sof_code(b);
      walk_mode = MODE_LEN_HI;
    end
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic lst,
                           output logic produced, output frame_info_t info);
    logic [15:0] seg_len;
    if (walk_seen < SEEN_MIN) begin
      walk_seen = walk_seen + 3'd1;
    end
    case (walk_mode)
      MODE_HDR0: begin
        walk_mode = (b == BYTE_FF) ? MODE_HDR1 : MODE_BAD;
      end
      MODE_HDR1: begin
        walk_mode = (b == MARK_SOI) ? MODE_SEEK : MODE_BAD;
      end
      MODE_SEEK: begin
        if (b == BYTE_FF) begin
          walk_mode = MODE_FILL;
        end
      end
      MODE_FILL: begin
        enter_marker(b);
      end
      MODE_LEN_HI: begin
        walk_len_hi = b;
        walk_mode   = MODE_LEN_LO;
      end
      MODE_LEN_LO: begin
        seg_len = {walk_len_hi, b};
        if (seg_len < LEN_MIN || (walk_sof && seg_len < SOF_LEN_MIN)) begin
          walk_mode = MODE_STOP;
        end else begin
          walk_left = seg_len - LEN_MIN;
          walk_off  = '0;
          walk_mode = (walk_left != 16'd0) ? MODE_BODY : MODE_SEEK;
        end
      end
      MODE_BODY: begin
        // body layout: precision, height hi/lo, width hi/lo, component count
        if (walk_sof) begin
          case (walk_off)
            3'd1: walk_height = {b, 8'h00};
            3'd2: walk_height = walk_height | {8'h00, b};
            3'd3: walk_width  = {b, 8'h00};
            3'd4: walk_width  = walk_width | {8'h00, b};
            3'd5: walk_comps  = b;
            default: begin
            end
          endcase
        end
        if (walk_off < OFFSET_MAX) begin
          walk_off = walk_off + 3'd1;
        end
        walk_left = walk_left - 16'd1;
        if (walk_left == 16'd0) begin
          walk_mode = walk_sof ? MODE_FOUND : MODE_SEEK;
        end
      end
      MODE_ENTROPY: begin
        if (b == BYTE_FF) begin
          walk_mode = MODE_ENT_FF;
        end
      end
      MODE_ENT_FF: begin
        // stuffed zero and restart markers stay inside the scan
        if (b == BYTE_00 || restart_code(b)) begin
          walk_mode = MODE_ENTROPY;
        end else begin
          enter_marker(b);
        end
      end
      default: begin
      end
    endcase
    produced = lst;
    info     = NO_INFO;
    if (lst) begin
      if (walk_seen < SEEN_MIN || walk_mode == MODE_BAD ||
          walk_mode == MODE_HDR0 || walk_mode == MODE_HDR1) begin
        info = NOT_JPEG_INFO;
      end else if (walk_mode == MODE_FOUND) begin
        info = {STATUS_DIMS, walk_width, walk_height, walk_comps};
      end else begin
        info = NO_DIMS_INFO;
      end
      walk_reset();
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) begin
      return 16'h0000;
    end else if (r == 1) begin
      return 16'hFFFF;
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [7:0] pick_sof();
    logic [7:0] m;
    do begin
      m = 8'($urandom_range(MARK_SOF0, MARK_SOF15));
    end while (!sof_code(m));
    return m;
  endfunction

  function automatic logic [7:0] pick_other_marker();
    case ($urandom_range(0, 7))
      0: return MARK_APP0;
      1: return MARK_COM;
      2: return MARK_DQT;
      3: return MARK_DHT;
      4: return MARK_JPG;
      5: return MARK_DAC;
      6: return BYTE_00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one random file: mostly well-formed marker streams, some noise and broken headers
  task automatic build_file();
    int unsigned kind;
    int unsigned nseg;
    int unsigned s;
    int unsigned n;
    logic [7:0]  m;
    logic [15:0] seg_len;
    logic [15:0] dim_h;
    logic [15:0] dim_w;
    file_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 8);
      repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (kind < 20) begin
      file_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : BYTE_FF);
      file_bytes.push_back(($urandom_range(0, 1) == 0) ?
                           (MARK_SOI ^ (8'h01 << $urandom_range(0, 7))) :
                           8'($urandom_range(0, 255)));
      n = $urandom_range(0, 4);
      repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    file_bytes.push_back(BYTE_FF);
    file_bytes.push_back(MARK_SOI);
    nseg = $urandom_range(1, 3);
    repeat (nseg) begin
      s = $urandom_range(0, 11);
      case (s)
        0: begin
          n = $urandom_range(1, 3);
          repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        1: begin
          file_bytes.push_back(BYTE_FF);
          n = $urandom_range(0, 2);
          repeat (n) file_bytes.push_back(BYTE_FF);
          file_bytes.push_back(($urandom_range(0, 2) == 0) ? MARK_TEM :
                               (MARK_RST0 + 8'($urandom_range(0, 7))));
        end
        2, 3, 9, 10: begin
          seg_len = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(9, 11)) : SOF_LEN_MIN;
          dim_h   = pick_dim();
          dim_w   = pick_dim();
          file_bytes.push_back(BYTE_FF);
          file_bytes.push_back(pick_sof());
          file_bytes.push_back(seg_len[15:8]);
          file_bytes.push_back(seg_len[7:0]);
          file_bytes.push_back(8'($urandom_range(0, 255)));
          file_bytes.push_back(dim_h[15:8]);
          file_bytes.push_back(dim_h[7:0]);
          file_bytes.push_back(dim_w[15:8]);
          file_bytes.push_back(dim_w[7:0]);
          file_bytes.push_back(8'($urandom_range(0, 255)));
          repeat (seg_len - SOF_LEN_MIN) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        4: begin
          seg_len = 16'($urandom_range(2, 6));
          file_bytes.push_back(BYTE_FF);
          file_bytes.push_back(pick_other_marker());
          file_bytes.push_back(seg_len[15:8]);
          file_bytes.push_back(seg_len[7:0]);
          repeat (seg_len - LEN_MIN) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        5: begin
          file_bytes.push_back(BYTE_FF);
          file_bytes.push_back(MARK_SOS);
          n = $urandom_range(2, 8);
          repeat (n) begin
            case ($urandom_range(0, 5))
              0: begin
                file_bytes.push_back(BYTE_FF);
                file_bytes.push_back(BYTE_00);
              end
              1: begin
                file_bytes.push_back(BYTE_FF);
                file_bytes.push_back(MARK_RST0 + 8'($urandom_range(0, 7)));
              end
              default: file_bytes.push_back(8'($urandom_range(0, 254)));
            endcase
          end
        end
        6: begin
          file_bytes.push_back(BYTE_FF);
          file_bytes.push_back(pick_other_marker());
          file_bytes.push_back(BYTE_00);
          file_bytes.push_back(8'($urandom_range(0, 1)));
        end
        7: begin
          seg_len = 16'($urandom_range(2, 7));
          file_bytes.push_back(BYTE_FF);
          file_bytes.push_back(pick_sof());
          file_bytes.push_back(seg_len[15:8]);
          file_bytes.push_back(seg_len[7:0]);
          repeat (seg_len - LEN_MIN) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          file_bytes.push_back(BYTE_FF);
          file_bytes.push_back(($urandom_range(0, 1) == 0) ? MARK_EOI : MARK_SOI);
        end
      endcase
    end
    // cut the file short inside whatever was being walked
    if (file_bytes.size() > 3 && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > n) file_bytes.pop_back();
    end
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic lst, input logic calm,
                           input logic typed, input frame_info_t want);
    int unsigned gap;
    logic        produced;
    frame_info_t info;
    gap = (calm || sink_holding) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    walk_byte(b, lst, produced, info);
    if (produced) begin
      pending_frames.push_back(typed ? want : info);
    end
    beats_sent++;
  endtask

  task automatic flag_mismatch(input string why, input frame_info_t want, input frame_info_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch (%s): expected status %0d w %0d h %0d c %0d, got status %0d w %0d h %0d c %0d",
               why, want.status, want.width, want.height, want.comps,
               got.status, got.width, got.height, got.comps);
    end
  endtask

  always @(posedge clk) begin : result_check
    frame_info_t got;
    frame_info_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[1:0], out_tdata[17:2], out_tdata[33:18], out_tdata[41:34]};
      if (got.status == STATUS_DIMS) begin
        dims_seen++;
      end
      if (pending_frames.size() == 0) begin
        flag_mismatch("no frame pending", NO_INFO, got);
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (got.status != want.status || got.width != want.width ||
            got.height != want.height || got.comps != want.comps) begin
          flag_mismatch("field", want, got);
        end
      end
    end
  end

  initial begin : ready_driver
    int unsigned g;
    int unsigned calm_left;
    int unsigned held;
    out_tready   <= 1'b0;
    sink_holding = 1'b0;
    hold_done    = 1'b0;
    calm_left    = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && files_sent >= HOLD_AFTER_FILES) begin
        // long back-pressure while the sender keeps pushing files without gaps
        hold_done    = 1'b1;
        sink_holding = 1'b1;
        out_tready   <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        sink_holding = 1'b0;
      end else begin
        if (calm_left > 0) begin
          g = 0;
          calm_left--;
        end else begin
          g = pick_gap();
          if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(20, 60);
          end
        end
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned i;
    int unsigned drain;
    logic        calm;
    rst_n          <= 1'b0;
    in_tvalid      <= 1'b0;
    in_tdata       <= 8'h00;
    in_tlast       <= 1'b0;
    files_sent     = 0;
    beats_sent     = 0;
    frames_checked = 0;
    dims_seen      = 0;
    mismatches     = 0;
    walk_reset();

    // too short to be a file
    directed_rows.push_back({BYTE_FF,   1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({MARK_SOI,  1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({MARK_EOI,  1'b1, 1'b1, NOT_JPEG_INFO});
    // wrong start marker
    directed_rows.push_back({BYTE_FF,   1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({MARK_RST7, 1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({BYTE_FF,   1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({MARK_EOI,  1'b1, 1'b1, NOT_JPEG_INFO});
    // minimal frame header with every field at its maximum
    directed_rows.push_back({BYTE_FF,   1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({MARK_SOI,  1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({BYTE_FF,   1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({MARK_SOF0, 1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({8'h00,     1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({8'h08,     1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({8'hFF,     1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({8'hFF,     1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({8'hFF,     1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({8'hFF,     1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({8'hFF,     1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({8'hFF,     1'b1, 1'b1, FULL_DIMS});
    // segment length below two
    directed_rows.push_back({BYTE_FF,   1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({MARK_SOI,  1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({BYTE_FF,   1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({MARK_APP0, 1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({8'h00,     1'b0, 1'b0, NO_INFO});
    directed_rows.push_back({8'h01,     1'b1, 1'b1, NO_DIMS_INFO});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < directed_rows.size(); i++) begin
      send_beat(directed_rows[i].data, directed_rows[i].lst, 1'b0,
                directed_rows[i].typed, directed_rows[i].want);
      if (directed_rows[i].lst) begin
        files_sent++;
      end
    end

    while (beats_sent < directed_rows.size() + RANDOM_BEATS) begin
      build_file();
      calm = ($urandom_range(0, 3) == 0);
      for (i = 0; i < file_bytes.size(); i++) begin
        send_beat(file_bytes[i], i == file_bytes.size() - 1, calm, 1'b0, NO_INFO);
      end
      files_sent++;
    end
    in_tvalid <= 1'b0;

    drain = 0;
    while (pending_frames.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (pending_frames.size() != 0) begin
      $display("%0d frames never reported", pending_frames.size());
      mismatches = mismatches + pending_frames.size();
    end

    $display("walked %0d files in %0d bytes; %0d reports checked, %0d with dimensions",
             files_sent, beats_sent, frames_checked, dims_seen);
    $display("output held off %0d cycles once; %0d mismatches", HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("timeout waiting for the parser");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== jpeg_frame_header_parser_core.f =====
design/jfhp_pkg.sv
design/jpeg_frame_header_parser_core.sv
design/jfhp_checker.sv
verif/jpeg_frame_header_parser_core_tb.sv
